@@ src/rtfh_pkg.sv @@
// ----------------------------------------------------------------------------
// rtfh_pkg
// Shared constants and types of the ray to triangle first-hit caster.
// ----------------------------------------------------------------------------
package rtfh_pkg;

  localparam int MAX_TRIS_DEF   = 1024;
  localparam int COORD_BITS_DEF = 32;

  localparam int CFG_W       = 16;
  localparam int DIST_BITS   = 31;
  localparam int TRI_ID_BITS = 10;
  localparam int R_BITS      = 32;
  localparam int FRAC_SHIFT  = 16;

  // 0.001 in Q16.16, rounded.
  localparam logic [CFG_W-1:0] MIN_LEN_Q = 16'd66;
  localparam logic [CFG_W-1:0] EPS_RESET = 16'd1;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_CAST  = 2'd2;

  localparam logic [0:0] CFG_DET_EPS  = 1'b0;
  localparam logic [0:0] CFG_DIST_EPS = 1'b1;

  typedef struct packed {
    logic start;
    logic b_neg;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

@@ src/rtfh_mul.sv @@
// ----------------------------------------------------------------------------
// rtfh_mul
// Shift-and-add multiplier: a signed operand times a magnitude with a sign,
// one bit of the magnitude per cycle, stopping early when no bits remain.
// ----------------------------------------------------------------------------
module rtfh_mul
  import rtfh_pkg::*;
#(
  parameter int A_W = 67,
  parameter int B_W = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mul_req_t                    req,
  input  logic signed [A_W-1:0]       a,
  input  logic        [B_W-1:0]       b_mag,
  output mul_stat_t                   stat,
  output logic signed [A_W+B_W-1:0]   prod
);

  localparam int P_W = A_W + B_W;

  logic                  run;
  logic                  fin;
  logic                  done;
  logic                  neg;
  logic signed [P_W-1:0] acc;
  logic signed [P_W-1:0] a_sh;
  logic [B_W-1:0]        b_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        fin <= 1'b0;
      end else if (run && b_rem == '0) begin
        run <= 1'b0;
        fin <= 1'b1;
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc   <= '0;
      a_sh  <= P_W'(a);
      b_rem <= b_mag;
      neg   <= req.b_neg;
    end else if (run && b_rem != '0) begin
      if (b_rem[0]) acc <= acc + a_sh;
      a_sh  <= a_sh <<< 1;
      b_rem <= b_rem >> 1;
    end else if (fin) begin
      prod <= neg ? -acc : acc;
    end
  end

  assign stat.busy = run | fin;
  assign stat.done = done;

endmodule

@@ src/ray_triangle_first_hit.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_first_hit
// Triangle store with a segment caster that reports the first triangle hit.
// ----------------------------------------------------------------------------
// Load and clear transfers are taken in the idle state. A cast runs on one
// shared shift-and-add multiplier, which stops early once no bits of its
// second operand remain. Setup takes 4 products and a square root; every
// stored triangle then takes a fetch from the triangle memory (ST_FETCH and
// ST_LATCH), 24 products and the checks in ST_NORM and ST_CHECK; the hit
// triangle adds a divider, a distance check and 4 more products. A result
// waits in the output register while the next transfer is taken in.
// ----------------------------------------------------------------------------
module ray_triangle_first_hit
  import rtfh_pkg::*;
#(
  parameter int MAX_TRIS   = MAX_TRIS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   cmd,
  input  logic signed [COORD_BITS-1:0] p0_x,
  input  logic signed [COORD_BITS-1:0] p0_y,
  input  logic signed [COORD_BITS-1:0] p0_z,
  input  logic signed [COORD_BITS-1:0] p1_x,
  input  logic signed [COORD_BITS-1:0] p1_y,
  input  logic signed [COORD_BITS-1:0] p1_z,
  input  logic signed [COORD_BITS-1:0] p2_x,
  input  logic signed [COORD_BITS-1:0] p2_y,
  input  logic signed [COORD_BITS-1:0] p2_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic signed [COORD_BITS-1:0] hit_x,
  output logic signed [COORD_BITS-1:0] hit_y,
  output logic signed [COORD_BITS-1:0] hit_z,
  output logic [DIST_BITS-1:0]         hit_distance,
  output logic [TRI_ID_BITS-1:0]       hit_triangle
);

  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;
  localparam int CW   = 2 * DW + 1;
  localparam int MA   = CW;
  localparam int MB   = (C > R_BITS) ? C : R_BITS;
  localparam int PW   = MA + MB;
  localparam int WW   = 3 * DW + 3;
  localparam int AW   = (WW > PW) ? WW : PW;
  localparam int SQW  = 2 * C + 2;
  localparam int LW   = C + 1;
  localparam int RW   = LW + 3;
  localparam int TIW  = (MAX_TRIS > 1) ? $clog2(MAX_TRIS) : 1;
  localparam int CNTW = $clog2(MAX_TRIS + 1);
  localparam int STW  = $clog2(((LW > R_BITS) ? LW : R_BITS) + 1);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SQ    = 5'd1;
  localparam logic [4:0] ST_ROOT  = 5'd2;
  localparam logic [4:0] ST_THR   = 5'd3;
  localparam logic [4:0] ST_FETCH = 5'd4;
  localparam logic [4:0] ST_LATCH = 5'd5;
  localparam logic [4:0] ST_H     = 5'd6;
  localparam logic [4:0] ST_A     = 5'd7;
  localparam logic [4:0] ST_UN    = 5'd8;
  localparam logic [4:0] ST_Q     = 5'd9;
  localparam logic [4:0] ST_VN    = 5'd10;
  localparam logic [4:0] ST_TN    = 5'd11;
  localparam logic [4:0] ST_NORM  = 5'd12;
  localparam logic [4:0] ST_CHECK = 5'd13;
  localparam logic [4:0] ST_DIV   = 5'd14;
  localparam logic [4:0] ST_DIST  = 5'd15;
  localparam logic [4:0] ST_DCHK  = 5'd16;
  localparam logic [4:0] ST_HITP  = 5'd17;
  localparam logic [4:0] ST_OUT   = 5'd18;

  function automatic logic [1:0] nxt(input logic [1:0] v);
    return (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  function automatic logic [MB-1:0] mag(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] m;
    m = v[DW-1] ? -v : v;
    return MB'($unsigned(m));
  endfunction

  function automatic logic signed [C-1:0] sat_c(input logic signed [C+1:0] v);
    if (v[C+1:C-1] == 3'b000 || v[C+1:C-1] == 3'b111) return v[C-1:0];
    else if (v[C+1]) return {1'b1, {(C-1){1'b0}}};
    else return {1'b0, {(C-1){1'b1}}};
  endfunction

  // Control state.
  logic [4:0]       state;
  logic [CNTW-1:0]  tri_count;
  logic [CNTW-1:0]  idx;
  logic [CFG_W-1:0] det_eps;
  logic [CFG_W-1:0] dist_eps;
  logic [1:0]       k;
  logic             t;
  logic             mwait;
  logic [STW-1:0]   step;
  logic             r_hit;

  // Datapath.
  logic [9*C-1:0]          tri_mem [MAX_TRIS];
  logic [9*C-1:0]          tri_rd;
  logic signed [C-1:0]     in_p [3][3];
  logic signed [C-1:0]     org [3];
  logic signed [DW-1:0]    dir [3];
  logic signed [DW-1:0]    e1 [3];
  logic signed [DW-1:0]    e2 [3];
  logic signed [DW-1:0]    sv [3];
  logic signed [CW-1:0]    hv [3];
  logic signed [CW-1:0]    qv [3];
  logic signed [C-1:0]     hx [3];
  logic signed [AW-1:0]    acc;
  logic signed [AW-1:0]    av;
  logic signed [AW-1:0]    un;
  logic signed [AW-1:0]    vn;
  logic signed [AW-1:0]    tn;
  logic [AW-1:0]           thr;
  logic [SQW-1:0]          root_x;
  logic [RW-1:0]           root_rem;
  logic [LW-1:0]           len;
  logic [AW:0]             div_rem;
  logic [R_BITS-1:0]       rq;
  logic [LW-1:0]           ray_dist;

  // Multiplier operands and results.
  mul_req_t                mreq;
  mul_stat_t               mstat;
  logic signed [MA-1:0]    mul_a;
  logic signed [DW-1:0]    b_val;
  logic [MB-1:0]           b_uns;
  logic                    b_is_uns;
  logic [MB-1:0]           mul_b;
  logic signed [PW-1:0]    mul_prod;
  logic signed [AW-1:0]    prod_ext;
  logic signed [AW-1:0]    sum;
  logic signed [AW-1:0]    dif;
  logic                    is_mul;
  logic                    mul_fire;

  logic                    accept;
  logic [CNTW-1:0]         idx_inc;
  logic signed [AW:0]      uv_sum;
  logic                    tri_pass;
  logic [RW-1:0]           rem_sh;
  logic [RW-1:0]           trial;
  logic                    root_ge;
  logic [AW:0]             drem_sh;
  logic                    div_ge;
  logic                    out_load;
  logic signed [C+1:0]     hit_val;
  logic [C-1:0]            off;

  assign in_p[0][0] = p0_x;
  assign in_p[0][1] = p0_y;
  assign in_p[0][2] = p0_z;
  assign in_p[1][0] = p1_x;
  assign in_p[1][1] = p1_y;
  assign in_p[1][2] = p1_z;
  assign in_p[2][0] = p2_x;
  assign in_p[2][1] = p2_y;
  assign in_p[2][2] = p2_z;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_inc  = idx + 1'b1;
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  assign is_mul = state inside {ST_SQ, ST_THR, ST_H, ST_A, ST_UN, ST_Q, ST_VN, ST_TN,
                                ST_DIST, ST_HITP};
  assign mul_fire = mwait && mstat.done;

  always_comb begin
    mul_a    = '0;
    b_val    = '0;
    b_uns    = '0;
    b_is_uns = 1'b0;
    case (state)
      ST_SQ: begin
        mul_a = MA'(dir[k]);
        b_val = dir[k];
      end
      ST_THR: begin
        mul_a    = MA'($signed({1'b0, len}));
        b_uns    = MB'(det_eps);
        b_is_uns = 1'b1;
      end
      ST_H: begin
        mul_a = t ? MA'(dir[nxt(nxt(k))]) : MA'(dir[nxt(k)]);
        b_val = t ? e2[nxt(k)] : e2[nxt(nxt(k))];
      end
      ST_A: begin
        mul_a = MA'(hv[k]);
        b_val = e1[k];
      end
      ST_UN: begin
        mul_a = MA'(hv[k]);
        b_val = sv[k];
      end
      ST_Q: begin
        mul_a = t ? MA'(sv[nxt(nxt(k))]) : MA'(sv[nxt(k)]);
        b_val = t ? e1[nxt(k)] : e1[nxt(nxt(k))];
      end
      ST_VN: begin
        mul_a = MA'(qv[k]);
        b_val = dir[k];
      end
      ST_TN: begin
        mul_a = MA'(qv[k]);
        b_val = e2[k];
      end
      ST_DIST: begin
        mul_a    = MA'($signed({1'b0, len}));
        b_uns    = MB'(rq);
        b_is_uns = 1'b1;
      end
      ST_HITP: begin
        mul_a    = MA'($signed({1'b0, rq}));
        b_uns    = mag(dir[k]);
        b_is_uns = 1'b1;
      end
      default: ;
    endcase
  end

  assign mul_b      = b_is_uns ? b_uns : mag(b_val);
  assign mreq.start = is_mul && !mwait;
  assign mreq.b_neg = !b_is_uns && b_val[DW-1];

  rtfh_mul #(
    .A_W (MA),
    .B_W (MB)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .req   (mreq),
    .a     (mul_a),
    .b_mag (mul_b),
    .stat  (mstat),
    .prod  (mul_prod)
  );

  assign prod_ext = AW'(mul_prod);
  assign sum      = acc + prod_ext;
  assign dif      = acc - prod_ext;

  // One bit pair of the square root a cycle.
  assign rem_sh  = {root_rem[RW-3:0], root_x[SQW-1 -: 2]};
  assign trial   = RW'({len, 2'b01});
  assign root_ge = rem_sh >= trial;

  // One quotient bit a cycle.
  assign drem_sh = {div_rem[AW-1:0], 1'b0};
  assign div_ge  = drem_sh >= {1'b0, $unsigned(av)};

  assign uv_sum   = (AW+1)'(un) + (AW+1)'(vn);
  assign tri_pass = (av != '0) && ($unsigned(av) >= thr) && !un[AW-1] && !vn[AW-1] &&
                    (uv_sum <= (AW+1)'(av)) && !tn[AW-1] && (tn != '0) && (tn < av);

  assign off     = prod_ext[R_BITS +: C];
  assign hit_val = dir[k][DW-1] ? (C+2)'(org[k]) - (C+2)'($signed({2'b00, off}))
                                : (C+2)'(org[k]) + (C+2)'($signed({2'b00, off}));

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tri_count <= '0;
      det_eps   <= EPS_RESET;
      dist_eps  <= EPS_RESET;
      out_valid <= 1'b0;
      mwait     <= 1'b0;
      k         <= 2'd0;
      t         <= 1'b0;
      step      <= '0;
      idx       <= '0;
      r_hit     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DET_EPS:  det_eps  <= cfg_data;
          CFG_DIST_EPS: dist_eps <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (mreq.start) mwait <= 1'b1;
      if (mul_fire) mwait <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_LOAD: begin
                if (tri_count < CNTW'(MAX_TRIS)) tri_count <= tri_count + 1'b1;
              end
              CMD_CLEAR: tri_count <= '0;
              CMD_CAST: begin
                state <= ST_SQ;
                k     <= 2'd0;
              end
              default: ;
            endcase
          end
        end
        ST_SQ: begin
          if (mul_fire) begin
            k <= nxt(k);
            if (k == 2'd2) begin
              state <= ST_ROOT;
              step  <= STW'(LW);
            end
          end
        end
        ST_ROOT: begin
          if (step != '0) begin
            step <= step - 1'b1;
          end else if (len < LW'(MIN_LEN_Q)) begin
            r_hit <= 1'b0;
            state <= ST_OUT;
          end else begin
            state <= ST_THR;
          end
        end
        ST_THR: begin
          if (mul_fire) begin
            idx <= '0;
            if (tri_count == '0) begin
              r_hit <= 1'b0;
              state <= ST_OUT;
            end else begin
              state <= ST_FETCH;
            end
          end
        end
        ST_FETCH: state <= ST_LATCH;
        ST_LATCH: begin
          state <= ST_H;
          k     <= 2'd0;
          t     <= 1'b0;
        end
        ST_H, ST_Q: begin
          if (mul_fire) begin
            t <= ~t;
            if (t) begin
              k <= nxt(k);
              if (k == 2'd2) state <= (state == ST_H) ? ST_A : ST_VN;
            end
          end
        end
        ST_A, ST_UN, ST_VN, ST_TN: begin
          if (mul_fire) begin
            k <= nxt(k);
            if (k == 2'd2) begin
              case (state)
                ST_A:    state <= ST_UN;
                ST_UN:   state <= ST_Q;
                ST_VN:   state <= ST_TN;
                default: state <= ST_NORM;
              endcase
            end
          end
        end
        ST_NORM: state <= ST_CHECK;
        ST_CHECK: begin
          if (tri_pass) begin
            state <= ST_DIV;
            step  <= STW'(R_BITS);
          end else if (idx_inc == tri_count) begin
            r_hit <= 1'b0;
            state <= ST_OUT;
          end else begin
            idx   <= idx_inc;
            state <= ST_FETCH;
          end
        end
        ST_DIV: begin
          if (step != '0) step <= step - 1'b1;
          else state <= ST_DIST;
        end
        ST_DIST: begin
          if (mul_fire) state <= ST_DCHK;
        end
        ST_DCHK: begin
          if (ray_dist > LW'(dist_eps)) begin
            state <= ST_HITP;
            k     <= 2'd0;
          end else if (idx_inc == tri_count) begin
            r_hit <= 1'b0;
            state <= ST_OUT;
          end else begin
            idx   <= idx_inc;
            state <= ST_FETCH;
          end
        end
        ST_HITP: begin
          if (mul_fire) begin
            k <= nxt(k);
            if (k == 2'd2) begin
              r_hit <= 1'b1;
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Triangle memory: one whole triangle per entry.
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_LOAD && tri_count < CNTW'(MAX_TRIS)) begin
      tri_mem[tri_count[TIW-1:0]] <= {p2_z, p2_y, p2_x, p1_z, p1_y, p1_x, p0_z, p0_y, p0_x};
    end
    if (state == ST_FETCH) tri_rd <= tri_mem[idx[TIW-1:0]];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_CAST) begin
      for (int j = 0; j < 3; j++) begin
        org[j] <= in_p[0][j];
        dir[j] <= DW'(in_p[1][j]) - DW'(in_p[0][j]);
      end
    end

    if (mul_fire) begin
      case (state)
        ST_SQ: begin
          acc <= (k == 2'd0) ? prod_ext : sum;
          if (k == 2'd2) root_x <= SQW'($unsigned(sum));
          root_rem <= '0;
          len      <= '0;
        end
        ST_THR: thr <= $unsigned(prod_ext) << FRAC_SHIFT;
        ST_H: begin
          if (!t) acc <= prod_ext;
          else hv[k] <= CW'(dif);
        end
        ST_Q: begin
          if (!t) acc <= prod_ext;
          else qv[k] <= CW'(dif);
        end
        ST_A, ST_UN, ST_VN, ST_TN: begin
          acc <= (k == 2'd0) ? prod_ext : sum;
          if (k == 2'd2) begin
            case (state)
              ST_A:    av <= sum;
              ST_UN:   un <= sum;
              ST_VN:   vn <= sum;
              default: tn <= sum;
            endcase
          end
        end
        ST_DIST: ray_dist <= prod_ext[R_BITS +: LW];
        ST_HITP: hx[k] <= sat_c(hit_val);
        default: ;
      endcase
    end

    if (state == ST_ROOT && step != '0) begin
      root_x <= root_x << 2;
      if (root_ge) begin
        root_rem <= rem_sh - trial;
        len      <= {len[LW-2:0], 1'b1};
      end else begin
        root_rem <= rem_sh;
        len      <= {len[LW-2:0], 1'b0};
      end
    end

    if (state == ST_LATCH) begin
      for (int j = 0; j < 3; j++) begin
        e1[j] <= DW'($signed(tri_rd[(3 + j)*C +: C])) - DW'($signed(tri_rd[j*C +: C]));
        e2[j] <= DW'($signed(tri_rd[(6 + j)*C +: C])) - DW'($signed(tri_rd[j*C +: C]));
        sv[j] <= DW'(org[j]) - DW'($signed(tri_rd[j*C +: C]));
      end
    end

    // A negative determinant flips the sign of all four terms.
    if (state == ST_NORM && av[AW-1]) begin
      av <= -av;
      un <= -un;
      vn <= -vn;
      tn <= -tn;
    end

    if (state == ST_CHECK) begin
      div_rem <= (AW+1)'($unsigned(tn));
      rq      <= '0;
    end

    if (state == ST_DIV && step != '0) begin
      if (div_ge) begin
        div_rem <= drem_sh - {1'b0, $unsigned(av)};
        rq      <= {rq[R_BITS-2:0], 1'b1};
      end else begin
        div_rem <= drem_sh;
        rq      <= {rq[R_BITS-2:0], 1'b0};
      end
    end

    if (out_load) begin
      hit <= r_hit;
      if (r_hit) begin
        hit_x        <= hx[0];
        hit_y        <= hx[1];
        hit_z        <= hx[2];
        hit_triangle <= TRI_ID_BITS'(idx);
        if ({{DIST_BITS{1'b0}}, ray_dist} > (LW+DIST_BITS)'({DIST_BITS{1'b1}}))
          hit_distance <= {DIST_BITS{1'b1}};
        else
          hit_distance <= DIST_BITS'(ray_dist);
      end else begin
        hit_x        <= '0;
        hit_y        <= '0;
        hit_z        <= '0;
        hit_triangle <= '0;
        hit_distance <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    tri_count <= CNTW'(MAX_TRIS))
    else $error("triangle count beyond store depth");

  a_mul_idle_start: assert property (@(posedge clk) disable iff (rst)
    mreq.start |-> !mstat.busy)
    else $error("multiplier started while busy");

  a_div_positive: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> (av != '0 && !av[AW-1]))
    else $error("division with a non-positive determinant");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> (hit_x == '0 && hit_y == '0 && hit_z == '0 &&
                           hit_distance == '0 && hit_triangle == '0))
    else $error("miss result with non-zero fields");

  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_CAST |=> !in_ready)
    else $error("input taken while a cast is running");
`endif

endmodule

@@ tb/sv/rtfh_checker.sv @@
// ----------------------------------------------------------------------------
// rtfh_checker
// Watches the configuration port and both channels of the first-hit caster,
// keeps its own copy of the triangle store, works out the result of every
// cast transfer and compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module rtfh_checker
  import rtfh_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [1:0]             cmd,
  input  logic signed [31:0]     p0_x,
  input  logic signed [31:0]     p0_y,
  input  logic signed [31:0]     p0_z,
  input  logic signed [31:0]     p1_x,
  input  logic signed [31:0]     p1_y,
  input  logic signed [31:0]     p1_z,
  input  logic signed [31:0]     p2_x,
  input  logic signed [31:0]     p2_y,
  input  logic signed [31:0]     p2_z,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   hit,
  input  logic signed [31:0]     hit_x,
  input  logic signed [31:0]     hit_y,
  input  logic signed [31:0]     hit_z,
  input  logic [DIST_BITS-1:0]   hit_distance,
  input  logic [TRI_ID_BITS-1:0] hit_triangle,
  output int                     errors,
  output int                     pending
);

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic                   hit;
    logic signed [31:0]     x;
    logic signed [31:0]     y;
    logic signed [31:0]     z;
    logic [DIST_BITS-1:0]   distance;
    logic [TRI_ID_BITS-1:0] tri_id;
  } hit_report_t;

  logic signed [31:0] tri_x [3*MAX_TRIS_DEF];
  logic signed [31:0] tri_y [3*MAX_TRIS_DEF];
  logic signed [31:0] tri_z [3*MAX_TRIS_DEF];
  int                 tri_count;
  logic [CFG_W-1:0]   det_eps;
  logic [CFG_W-1:0]   dist_eps;
  hit_report_t        reports_q [$];

  function automatic logic signed [31:0] clamp_coord(input wide_t v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic hit_report_t trace_segment(input wide_t st[3], input wide_t en[3]);
    hit_report_t rep;
    wide_t d[3], e1[3], e2[3], s[3], h[3], q[3];
    wide_t sum, len, cand, res, thr, a, un, vn, tn, r, ray_dist, off, mag, val;
    rep = '{hit: 1'b0, x: '0, y: '0, z: '0, distance: '0, tri_id: '0};
    for (int k = 0; k < 3; k++) d[k] = en[k] - st[k];
    sum = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
    res = 0;
    for (int b = 51; b >= 0; b--) begin
      cand = res | (wide_t'(1) << b);
      if (cand*cand <= sum) res = cand;
    end
    len = res;
    if (len < MIN_LEN_Q) return rep;
    thr = len * (wide_t'(det_eps) << FRAC_SHIFT);
    for (int i = 0; i < tri_count; i++) begin
      e1[0] = wide_t'(tri_x[3*i+1]) - tri_x[3*i];
      e1[1] = wide_t'(tri_y[3*i+1]) - tri_y[3*i];
      e1[2] = wide_t'(tri_z[3*i+1]) - tri_z[3*i];
      e2[0] = wide_t'(tri_x[3*i+2]) - tri_x[3*i];
      e2[1] = wide_t'(tri_y[3*i+2]) - tri_y[3*i];
      e2[2] = wide_t'(tri_z[3*i+2]) - tri_z[3*i];
      s[0] = st[0] - tri_x[3*i];
      s[1] = st[1] - tri_y[3*i];
      s[2] = st[2] - tri_z[3*i];
      h[0] = d[1]*e2[2] - d[2]*e2[1];
      h[1] = d[2]*e2[0] - d[0]*e2[2];
      h[2] = d[0]*e2[1] - d[1]*e2[0];
      a = e1[0]*h[0] + e1[1]*h[1] + e1[2]*h[2];
      if (a == 0) continue;
      un = s[0]*h[0] + s[1]*h[1] + s[2]*h[2];
      q[0] = s[1]*e1[2] - s[2]*e1[1];
      q[1] = s[2]*e1[0] - s[0]*e1[2];
      q[2] = s[0]*e1[1] - s[1]*e1[0];
      vn = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
      tn = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
      if (a < 0) begin
        a = -a; un = -un; vn = -vn; tn = -tn;
      end
      if (a < thr) continue;
      if (un < 0 || un > a) continue;
      if (vn < 0 || un + vn > a) continue;
      if (tn <= 0 || tn >= a) continue;
      r = (tn <<< R_BITS) / a;
      ray_dist = (len * r) >>> R_BITS;
      if (ray_dist <= dist_eps) continue;
      rep.hit = 1'b1;
      for (int k = 0; k < 3; k++) begin
        mag = (d[k] < 0) ? -d[k] : d[k];
        off = (mag * r) >>> R_BITS;
        val = (d[k] < 0) ? st[k] - off : st[k] + off;
        if (k == 0) rep.x = clamp_coord(val);
        else if (k == 1) rep.y = clamp_coord(val);
        else rep.z = clamp_coord(val);
      end
      rep.distance = (ray_dist > 64'sh7FFFFFFF) ? 31'h7FFFFFFF : ray_dist[30:0];
      rep.tri_id = i[TRI_ID_BITS-1:0];
      return rep;
    end
    return rep;
  endfunction

  always @(posedge clk) begin
    hit_report_t want;
    wide_t st[3], en[3];
    if (rst) begin
      tri_count = 0;
      det_eps = EPS_RESET;
      dist_eps = EPS_RESET;
      reports_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DET_EPS) det_eps = cfg_data;
        else dist_eps = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (reports_q.size() == 0) begin
          $display("%0t: result transfer with no cast outstanding", $time);
          errors++;
        end else begin
          want = reports_q.pop_front();
          if (hit !== want.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, want.hit, hit);
            errors++;
          end
          if (hit_x !== want.x) begin
            $display("%0t: hit_x expected %0d actual %0d", $time, want.x, hit_x);
            errors++;
          end
          if (hit_y !== want.y) begin
            $display("%0t: hit_y expected %0d actual %0d", $time, want.y, hit_y);
            errors++;
          end
          if (hit_z !== want.z) begin
            $display("%0t: hit_z expected %0d actual %0d", $time, want.z, hit_z);
            errors++;
          end
          if (hit_distance !== want.distance) begin
            $display("%0t: hit_distance expected %0d actual %0d", $time, want.distance,
                     hit_distance);
            errors++;
          end
          if (hit_triangle !== want.tri_id) begin
            $display("%0t: hit_triangle expected %0d actual %0d", $time, want.tri_id,
                     hit_triangle);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (cmd)
          CMD_LOAD: begin
            if (tri_count < MAX_TRIS_DEF) begin
              tri_x[3*tri_count] = p0_x; tri_y[3*tri_count] = p0_y;
              tri_z[3*tri_count] = p0_z;
              tri_x[3*tri_count+1] = p1_x; tri_y[3*tri_count+1] = p1_y;
              tri_z[3*tri_count+1] = p1_z;
              tri_x[3*tri_count+2] = p2_x; tri_y[3*tri_count+2] = p2_y;
              tri_z[3*tri_count+2] = p2_z;
              tri_count++;
            end
          end
          CMD_CLEAR: tri_count = 0;
          CMD_CAST: begin
            st[0] = p0_x; st[1] = p0_y; st[2] = p0_z;
            en[0] = p1_x; en[1] = p1_y; en[2] = p1_z;
            reports_q.push_back(trace_segment(st, en));
          end
          default: ;
        endcase
      end
    end
    pending = reports_q.size();
  end

endmodule

@@ tb/sv/tb_ray_triangle_first_hit.sv @@
// ----------------------------------------------------------------------------
// tb_ray_triangle_first_hit
// Drives loads, clears and casts into the first-hit caster with random gaps
// and back-pressure; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ray_triangle_first_hit;
  import rtfh_pkg::*;

  localparam int IDLE_LIMIT = 150000;
  localparam int N_RANDOM   = 580;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_DET_EPS;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = CMD_LOAD;
  logic signed [31:0] p0_x = 0, p0_y = 0, p0_z = 0;
  logic signed [31:0] p1_x = 0, p1_y = 0, p1_z = 0;
  logic signed [31:0] p2_x = 0, p2_y = 0, p2_z = 0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic signed [31:0] hit_x, hit_y, hit_z;
  logic [DIST_BITS-1:0] hit_distance;
  logic [TRI_ID_BITS-1:0] hit_triangle;
  int errors, pending;
  logic quiet = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  int fill = 0;
  int cx = 0, cy = 0, cz = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ray_triangle_first_hit uut (.*);

  rtfh_checker checker_i (.*);

  // Receiver back-pressure in bursts; none once the quiet tail starts.
  always @(posedge clk) begin
    if (quiet || rst) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_ray_triangle_first_hit failed");
      $finish;
    end
  end

  task automatic transfer_item(input logic [1:0] c,
                               input logic signed [31:0] ax, ay, az,
                               input logic signed [31:0] bx, by, bz,
                               input logic signed [31:0] qx, qy, qz);
    in_valid <= 1'b1;
    cmd <= c;
    p0_x <= ax; p0_y <= ay; p0_z <= az;
    p1_x <= bx; p1_y <= by; p1_z <= bz;
    p2_x <= qx; p2_y <= qy; p2_z <= qz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (c == CMD_LOAD && fill < MAX_TRIS_DEF) fill++;
    if (c == CMD_CLEAR) fill = 0;
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Waits for every outstanding cast result before the registers change.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_small();
    logic signed [31:0] v [9];
    for (int k = 0; k < 9; k++) v[k] = $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
    cx = (v[0] + v[3] + v[6]) / 3;
    cy = (v[1] + v[4] + v[7]) / 3;
    cz = (v[2] + v[5] + v[8]) / 3;
    transfer_item(CMD_LOAD, v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
  endtask

  // A segment near the centroid of the last small triangle loaded, mostly along z.
  task automatic cast_through();
    int zs, dx, dy;
    zs = $urandom_range(1, 32'h400000);
    dx = $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
    dy = $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
    transfer_item(CMD_CAST, cx - dx, cy - dy, cz - zs, cx + dx, cy + dy,
                  cz + $urandom_range(1, 32'h400000), $urandom, $urandom, $urandom);
  endtask

  initial begin
    int pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty store, a plain hit, short segment, unknown command.
    transfer_item(CMD_CAST, 0, 0, -32'sh10000, 0, 0, 32'sh10000, 0, 0, 0);
    transfer_item(CMD_LOAD, 0, 0, 0, 32'sh40000, 0, 0, 0, 32'sh40000, 0);
    transfer_item(CMD_CAST, 32'sh10000, 32'sh10000, -32'sh10000,
                  32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0);
    transfer_item(CMD_CAST, 32'sh10000, 32'sh10000, 0, 32'sh10000 + 10, 32'sh10000, 0,
                  0, 0, 0);
    transfer_item(CMD_CAST, 32'sh10000, 32'sh10000, 32'sh10000,
                  32'sh10000, 32'sh10000, -32'sh10000, 0, 0, 0);
    transfer_item(2'd3, -1, -1, -1, -1, -1, -1, -1, -1, -1);
    transfer_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // Degenerate triangle: the determinant is zero.
    transfer_item(CMD_LOAD, 0, 0, 0, 32'sh10000, 0, 0, 32'sh20000, 0, 0);
    transfer_item(CMD_CAST, 0, 0, -32'sh10000, 0, 0, 32'sh10000, 0, 0, 0);
    drain();
    write_reg(CFG_DET_EPS, 16'd0);
    write_reg(CFG_DIST_EPS, 16'd0);
    transfer_item(CMD_CAST, 0, 0, -32'sh10000, 0, 0, 32'sh10000, 0, 0, 0);
    transfer_item(CMD_LOAD, 32'sh80000000, 32'sh80000000, 0,
                  32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh80000000, 32'sh7FFFFFFF, 0);
    transfer_item(CMD_CAST, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                  32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0);
    transfer_item(CMD_CAST, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                  32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, -1, -1, -1);
    drain();
    write_reg(CFG_DET_EPS, 16'hFFFF);
    write_reg(CFG_DIST_EPS, 16'hFFFF);
    transfer_item(CMD_CAST, 32'sh10000, 32'sh10000, -32'sh10000,
                  32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0);

    // Full store: the hit triangle first, then small ones until loads are ignored.
    drain();
    write_reg(CFG_DET_EPS, EPS_RESET);
    write_reg(CFG_DIST_EPS, EPS_RESET);
    transfer_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    transfer_item(CMD_LOAD, 0, 0, 0, 32'sh40000, 0, 0, 0, 32'sh40000, 0);
    for (int i = 0; i < MAX_TRIS_DEF + 1; i++)
      transfer_item(CMD_LOAD, i, 1, 2, 3, i, 5, 6, 7, i);
    transfer_item(CMD_CAST, 32'sh10000, 32'sh10000, -32'sh10000,
                  32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0);
    transfer_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 70 == 69) begin
        drain();
        pick = $urandom_range(0, 3);
        write_reg(CFG_DET_EPS, pick == 0 ? 16'd0 : pick == 1 ? 16'hFFFF
                               : CFG_W'($urandom));
        pick = $urandom_range(0, 3);
        write_reg(CFG_DIST_EPS, pick == 0 ? 16'd0 : pick == 1 ? 16'hFFFF
                                : CFG_W'($urandom_range(0, 255)));
      end
      if (n == N_RANDOM - 60) quiet <= 1'b1;
      sender_gap();
      pick = $urandom_range(0, 99);
      if (fill >= 8 || pick < 8)
        transfer_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
      else if (pick < 40)
        load_small();
      else if (pick < 48)
        transfer_item(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
      else if (pick < 85)
        cast_through();
      else if (pick < 95)
        transfer_item(CMD_CAST, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
      else
        transfer_item(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb_ray_triangle_first_hit passed");
    end else begin
      $display("tb_ray_triangle_first_hit failed");
    end
    $finish;
  end

endmodule
